// ===== hw/rtl/symmetric_3x3_inverse_defines.svh =====
// Assertion macros for the symmetric 3x3 inverse.
`ifndef SYMMETRIC_3X3_INVERSE_DEFINES_SVH
`define SYMMETRIC_3X3_INVERSE_DEFINES_SVH

// same-cycle implication
`define SYM3_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sym3 check failed");

// next-cycle implication, no reset qualifier
`define SYM3_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sym3 check failed");

`endif

// ===== hw/rtl/sym3_pkg.sv =====
package sym3_pkg;

   localparam int InW      = 18;
   localparam int ProdW    = 2 * InW;
   localparam int CofW     = ProdW + 1;
   localparam int DetProdW = InW + CofW;
   localparam int DetW     = 56;
   localparam int MagW     = DetW - 1;
   localparam int QuoW     = 32;
   localparam int NumCof   = 6;
   localparam int NumProd  = 12;
   localparam int DivSteps = QuoW;

   typedef struct packed {
      logic signed [InW-1:0] m_xx;
      logic signed [InW-1:0] m_xy;
      logic signed [InW-1:0] m_xz;
      logic signed [InW-1:0] m_yy;
      logic signed [InW-1:0] m_yz;
      logic signed [InW-1:0] m_zz;
   } mat_type;

   typedef struct packed {
      logic [NumProd-1:0][ProdW-1:0] p;
      logic signed [InW-1:0]         xx;
      logic signed [InW-1:0]         xy;
      logic signed [InW-1:0]         xz;
   } prod_type;

   // c order: xx, xy, xz, yy, yz, zz
   typedef struct packed {
      logic [NumCof-1:0][CofW-1:0] c;
      logic signed [InW-1:0]       xx;
      logic signed [InW-1:0]       xy;
      logic signed [InW-1:0]       xz;
   } cof_type;

   typedef struct packed {
      logic [NumCof-1:0][CofW-1:0] c;
      logic [2:0][DetProdW-1:0]    dp;
   } detp_type;

   typedef struct packed {
      logic [NumCof-1:0][CofW-1:0] c;
      logic [DetW-1:0]             det;
   } dets_type;

   typedef struct packed {
      logic [MagW-1:0] r;
      logic [QuoW-1:0] q;
      logic            ovf;
      logic            neg;
   } div_lane_type;

   typedef struct packed {
      div_lane_type [NumCof-1:0] lane;
      logic [MagW-1:0]           d;
      logic [DetW-1:0]           det;
      logic                      singular;
   } div_item_type;

   typedef struct packed {
      logic [NumCof-1:0][QuoW-1:0] inv;
      logic [DetW-1:0]             det;
      logic                        singular;
      logic                        saturated;
   } res_type;

endpackage

// ===== hw/rtl/symmetric_3x3_inverse.sv =====
// channel  | dir | tdata (low bit up)                             | tuser
// req_     | in  | m_xx, m_xy, m_xz, m_yy, m_yz, m_zz (18b each) | -
// rsp_     | out | inv_xx..inv_zz (32b each), determinant (56b)   | singular, saturated
//
// One matrix per cycle sustained while rsp_tready is high; the stages are 2 cofactor, 3 determinant,
// 32 quotient bits of the restoring divider and 1 result.
// Each stage holds its own valid bit and takes new data when empty or draining,
// so bubbles collapse under backpressure and nothing is dropped or repeated.
// Synchronous active-high reset clears all valid bits.
`include "symmetric_3x3_inverse_defines.svh"

module symmetric_3x3_inverse (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // m_xx, m_xy, m_xz, m_yy, m_yz, m_zz, 4b zero
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [247:0] rsp_tdata,   // inv_xx, inv_xy, inv_xz, inv_yy, inv_yz, inv_zz, determinant
   output logic [1:0]   rsp_tuser    // singular, saturated
);

   localparam int W = sym3_pkg::InW;

   sym3_pkg::mat_type      mat;
   sym3_pkg::cof_type      cof;
   sym3_pkg::res_type      res;
   logic                   cof_valid, cof_ready;
   logic                   div_valid [sym3_pkg::DivSteps+1];
   logic                   div_ready [sym3_pkg::DivSteps+1];
   sym3_pkg::div_item_type div_data  [sym3_pkg::DivSteps+1];

   assign mat.m_xx = req_tdata[0*W +: W];
   assign mat.m_xy = req_tdata[1*W +: W];
   assign mat.m_xz = req_tdata[2*W +: W];
   assign mat.m_yy = req_tdata[3*W +: W];
   assign mat.m_yz = req_tdata[4*W +: W];
   assign mat.m_zz = req_tdata[5*W +: W];

   sym3_cof u_cof (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (mat),
      .out_valid (cof_valid),
      .out_ready (cof_ready),
      .out_data  (cof)
   );

   sym3_det u_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_valid),
      .in_ready  (cof_ready),
      .in_data   (cof),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   for (genvar s = 0; s < sym3_pkg::DivSteps; s++) begin : g_div
      sym3_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[s]),
         .in_ready  (div_ready[s]),
         .in_data   (div_data[s]),
         .out_valid (div_valid[s+1]),
         .out_ready (div_ready[s+1]),
         .out_data  (div_data[s+1])
      );
   end

   sym3_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid[sym3_pkg::DivSteps]),
      .in_ready  (div_ready[sym3_pkg::DivSteps]),
      .in_data   (div_data[sym3_pkg::DivSteps]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res)
   );

   assign rsp_tdata = {res.det, res.inv};
   assign rsp_tuser = {res.saturated, res.singular};

   `SYM3_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_tvalid)
   `SYM3_ASSERT_NOW(a_singular_zero, clock, reset, rsp_tvalid && rsp_tuser[0],
      rsp_tdata == '0 && !rsp_tuser[1])
   `SYM3_ASSERT_NOW(a_det_nonzero, clock, reset, rsp_tvalid && !rsp_tuser[0],
      rsp_tdata[247:192] != '0)

endmodule

// ===== hw/rtl/sym3_cof.sv =====
module sym3_cof (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  sym3_pkg::mat_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output sym3_pkg::cof_type  out_data
);

   logic               v1_ff, v2_ff, en1, en2;
   sym3_pkg::prod_type prod_ff, prod_in;
   sym3_pkg::cof_type  cof_ff, cof_in;

   assign en2       = !v2_ff || out_ready;
   assign en1       = !v1_ff || en2;
   assign in_ready  = en1;
   assign out_valid = v2_ff;
   assign out_data  = cof_ff;

   always_comb begin
      logic signed [sym3_pkg::ProdW-1:0] p [sym3_pkg::NumProd];
      p[0]  = in_data.m_yy * in_data.m_zz;
      p[1]  = in_data.m_yz * in_data.m_yz;
      p[2]  = in_data.m_xz * in_data.m_yz;
      p[3]  = in_data.m_xy * in_data.m_zz;
      p[4]  = in_data.m_xy * in_data.m_yz;
      p[5]  = in_data.m_xz * in_data.m_yy;
      p[6]  = in_data.m_xx * in_data.m_zz;
      p[7]  = in_data.m_xz * in_data.m_xz;
      p[8]  = in_data.m_xy * in_data.m_xz;
      p[9]  = in_data.m_xx * in_data.m_yz;
      p[10] = in_data.m_xx * in_data.m_yy;
      p[11] = in_data.m_xy * in_data.m_xy;
      for (int k = 0; k < sym3_pkg::NumProd; k++) begin
         prod_in.p[k] = p[k];
      end
      prod_in.xx = in_data.m_xx;
      prod_in.xy = in_data.m_xy;
      prod_in.xz = in_data.m_xz;
   end

   always_comb begin
      logic signed [sym3_pkg::CofW-1:0] c;
      for (int k = 0; k < sym3_pkg::NumCof; k++) begin
         c = $signed(prod_ff.p[2*k]) - $signed(prod_ff.p[2*k+1]);
         cof_in.c[k] = c;
      end
      cof_in.xx = prod_ff.xx;
      cof_in.xy = prod_ff.xy;
      cof_in.xz = prod_ff.xz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) prod_ff <= prod_in;
      if (en2) cof_ff <= cof_in;
   end

endmodule

// ===== hw/rtl/sym3_det.sv =====
module sym3_det (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  sym3_pkg::cof_type      in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sym3_pkg::div_item_type out_data
);

   logic                   v3_ff, v4_ff, v5_ff, en3, en4, en5;
   sym3_pkg::detp_type     detp_ff, detp_in;
   sym3_pkg::dets_type     dets_ff, dets_in;
   sym3_pkg::div_item_type item_ff, item_in;

   assign en5       = !v5_ff || out_ready;
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign in_ready  = en3;
   assign out_valid = v5_ff;
   assign out_data  = item_ff;

   always_comb begin
      logic signed [sym3_pkg::DetProdW-1:0] dp [3];
      dp[0] = in_data.xx * $signed(in_data.c[0]);
      dp[1] = in_data.xy * $signed(in_data.c[1]);
      dp[2] = in_data.xz * $signed(in_data.c[2]);
      for (int k = 0; k < 3; k++) begin
         detp_in.dp[k] = dp[k];
      end
      detp_in.c = in_data.c;
   end

   always_comb begin
      logic signed [sym3_pkg::DetW-1:0] s;
      s = $signed(detp_ff.dp[0]) + $signed(detp_ff.dp[1]) + $signed(detp_ff.dp[2]);
      dets_in.det = s;
      dets_in.c   = detp_ff.c;
   end

   always_comb begin
      logic [sym3_pkg::CofW-1:0] n;
      logic [sym3_pkg::DetW-1:0] dneg;
      dneg = ~dets_ff.det + 1'b1;
      item_in.d = dets_ff.det[sym3_pkg::DetW-1] ? dneg[sym3_pkg::MagW-1:0]
                                                : dets_ff.det[sym3_pkg::MagW-1:0];
      item_in.det      = dets_ff.det;
      item_in.singular = (dets_ff.det == '0);
      for (int k = 0; k < sym3_pkg::NumCof; k++) begin
         n = dets_ff.c[k][sym3_pkg::CofW-1] ? (~dets_ff.c[k] + 1'b1) : dets_ff.c[k];
         item_in.lane[k].r   = sym3_pkg::MagW'(n);
         item_in.lane[k].q   = '0;
         item_in.lane[k].ovf = (sym3_pkg::MagW'(n) >= item_in.d);
         item_in.lane[k].neg = dets_ff.c[k][sym3_pkg::CofW-1]
                               ^ dets_ff.det[sym3_pkg::DetW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en3) v3_ff <= in_valid;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) detp_ff <= detp_in;
      if (en4) dets_ff <= dets_in;
      if (en5) item_ff <= item_in;
   end

endmodule

// ===== hw/rtl/sym3_div_step.sv =====
module sym3_div_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  sym3_pkg::div_item_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sym3_pkg::div_item_type out_data
);

   logic                   v_ff, en;
   sym3_pkg::div_item_type item_ff, item_in;

   assign en        = !v_ff || out_ready;
   assign in_ready  = en;
   assign out_valid = v_ff;
   assign out_data  = item_ff;

   // one restoring quotient bit per lane
   always_comb begin
      logic [sym3_pkg::MagW:0] r2;
      item_in = in_data;
      for (int k = 0; k < sym3_pkg::NumCof; k++) begin
         r2 = {in_data.lane[k].r, 1'b0};
         if (r2 >= {1'b0, in_data.d}) begin
            r2 = r2 - {1'b0, in_data.d};
            item_in.lane[k].q = {in_data.lane[k].q[sym3_pkg::QuoW-2:0], 1'b1};
         end else begin
            item_in.lane[k].q = {in_data.lane[k].q[sym3_pkg::QuoW-2:0], 1'b0};
         end
         item_in.lane[k].r = r2[sym3_pkg::MagW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) item_ff <= item_in;
   end

endmodule

// ===== hw/rtl/sym3_out.sv =====
module sym3_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  sym3_pkg::div_item_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sym3_pkg::res_type      out_data
);

   localparam logic [sym3_pkg::QuoW-1:0] PosLimit = {1'b0, {(sym3_pkg::QuoW-1){1'b1}}};
   localparam logic [sym3_pkg::QuoW-1:0] NegLimit = {1'b1, {(sym3_pkg::QuoW-1){1'b0}}};

   logic              v_ff, en;
   sym3_pkg::res_type res_ff, res_in;

   assign en        = !v_ff || out_ready;
   assign in_ready  = en;
   assign out_valid = v_ff;
   assign out_data  = res_ff;

   always_comb begin
      logic sat;
      logic clip;
      sat = 1'b0;
      for (int k = 0; k < sym3_pkg::NumCof; k++) begin
         if (in_data.lane[k].neg) begin
            clip = in_data.lane[k].ovf || (in_data.lane[k].q > NegLimit);
            res_in.inv[k] = clip ? NegLimit : (~in_data.lane[k].q + 1'b1);
         end else begin
            clip = in_data.lane[k].ovf || (in_data.lane[k].q > PosLimit);
            res_in.inv[k] = clip ? PosLimit : in_data.lane[k].q;
         end
         sat = sat | clip;
         if (in_data.singular) res_in.inv[k] = '0;
      end
      res_in.det       = in_data.det;
      res_in.singular  = in_data.singular;
      res_in.saturated = sat && !in_data.singular;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) res_ff <= res_in;
   end

endmodule
